/* hw/rtl/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, register codes and stage records of the pressure
// compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

   localparam int RAW_W   = 24;
   localparam int COEF_W  = 16;
   localparam int OUT_W   = 32;
   localparam int CSR_IDX_W = 3;

   localparam logic [19:0] TEMP_REF    = 20'd2000;
   localparam logic [19:0] TEMP_VLOW_OFS = 20'd3500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_C1 = 3'd0,
      CSR_C2 = 3'd1,
      CSR_C3 = 3'd2,
      CSR_C4 = 3'd3,
      CSR_C5 = 3'd4,
      CSR_C6 = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [COEF_W-1:0] c1;
      logic [COEF_W-1:0] c2;
      logic [COEF_W-1:0] c3;
      logic [COEF_W-1:0] c4;
      logic [COEF_W-1:0] c5;
      logic [COEF_W-1:0] c6;
   } coef_type;

   // first-order terms
   typedef struct packed {
      logic [RAW_W-1:0] d1;
      logic [19:0]      temp1;
      logic [35:0]      off1;
      logic [34:0]      sens1;
      logic [17:0]      t2;
      logic [18:0]      lo;
      logic [19:0]      vl;
      logic             low;
      logic             vlow;
   } fo_type;

   // compensated terms
   typedef struct packed {
      logic [RAW_W-1:0] d1;
      logic [20:0]      temp;
      logic [39:0]      off;
      logic [39:0]      sens;
   } so_type;

endpackage

`default_nettype wire

/* hw/rtl/bpc_if.sv */
// ----------------------------------------------------------------------------
// bpc_if
// Valid/ready channels of the pressure compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpc_req_if;
   logic                       valid;
   logic                       ready;
   logic [bpc_pkg::RAW_W-1:0]  raw_pressure;
   logic [bpc_pkg::RAW_W-1:0]  raw_temperature;
   modport source (output valid, raw_pressure, raw_temperature, input ready);
   modport sink   (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface bpc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [bpc_pkg::OUT_W-1:0] temperature_centi;
   logic signed [bpc_pkg::OUT_W-1:0] pressure_centi;
   modport source (output valid, temperature_centi, pressure_centi, input ready);
   modport sink   (input valid, temperature_centi, pressure_centi, output ready);
endinterface

interface bpc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [bpc_pkg::CSR_IDX_W-1:0] index;
   logic [bpc_pkg::COEF_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/barometric_pressure_compensation_unit.sv */
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_unit
// Second-order compensated temperature and pressure from raw conversions.
// ----------------------------------------------------------------------------
// req_bus carries one raw pressure and temperature pair per beat; rsp_bus
// returns the temperature and pressure in hundredths, one beat per request,
// in order. csr_bus writes the six calibration coefficients (index 0..5,
// other indexes ignored); it is always ready and should only be written
// while no request is in flight.
// An accepted request beat reaches its response beat through eight pipeline
// stages (temperature difference, first-order products, first-order terms,
// squares, correction terms, correction apply, split sensitivity product,
// recombination) and the result register.
// Throughput is one beat per cycle while the receiver is ready, set by the fully pipelined multipliers.
// When the receiver stalls, one further result lands in a skid entry and
// then the whole pipeline holds and req_bus.ready drops until the stall
// clears; nothing is dropped or repeated.
// Reset clears all coefficients to zero and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module barometric_pressure_compensation_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   bpc_req_if.sink     req_bus,
   bpc_rsp_if.source   rsp_bus,
   bpc_csr_if.sink     csr_bus
);

   bpc_pkg::coef_type  coef;
   bpc_pkg::fo_type    fo_data;
   bpc_pkg::so_type    so_data;
   logic               fo_valid;
   logic               so_valid;
   logic               en;

   assign req_bus.ready = en;

   bpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .coef    (coef)
   );

   bpc_first_order u_first (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (req_bus.valid),
      .raw_pressure    (req_bus.raw_pressure),
      .raw_temperature (req_bus.raw_temperature),
      .coef            (coef),
      .out_valid       (fo_valid),
      .out_data        (fo_data)
   );

   bpc_second_order u_second (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fo_valid),
      .in_data   (fo_data),
      .out_valid (so_valid),
      .out_data  (so_data)
   );

   bpc_pressure u_pressure (
      .clock    (clock),
      .reset    (reset),
      .in_valid (so_valid),
      .in_data  (so_data),
      .en       (en),
      .rsp_bus  (rsp_bus)
   );

   // skid entry in use implies a result is being offered
   a_hold_has_rsp: assert property (@(posedge clock) disable iff (reset)
      !en |-> rsp_bus.valid)
      else $error("pipeline held without a pending response");

   a_hold_keeps: assert property (@(posedge clock) disable iff (reset)
      (!en && !rsp_bus.ready) |=> !en)
      else $error("skid entry lost while receiver stalled");

   a_hold_drains: assert property (@(posedge clock) disable iff (reset)
      (!en && rsp_bus.ready) |=> en)
      else $error("skid entry not drained after response beat");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_bus.valid && en))
      else $error("output not empty after reset");

endmodule

`default_nettype wire

/* hw/rtl/bpc_csr.sv */
// ----------------------------------------------------------------------------
// bpc_csr
// Calibration coefficient registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   bpc_csr_if.sink             csr_bus,
   output bpc_pkg::coef_type   coef
);

   bpc_pkg::coef_type coef_ff, coef_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      coef_in = coef_ff;
      if (csr_bus.valid) begin
         unique case (bpc_pkg::csr_index_type'(csr_bus.index))
            bpc_pkg::CSR_C1: coef_in.c1 = csr_bus.data;
            bpc_pkg::CSR_C2: coef_in.c2 = csr_bus.data;
            bpc_pkg::CSR_C3: coef_in.c3 = csr_bus.data;
            bpc_pkg::CSR_C4: coef_in.c4 = csr_bus.data;
            bpc_pkg::CSR_C5: coef_in.c5 = csr_bus.data;
            bpc_pkg::CSR_C6: coef_in.c6 = csr_bus.data;
            default:         coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

`default_nettype wire

/* hw/rtl/bpc_first_order.sv */
// ----------------------------------------------------------------------------
// bpc_first_order
// Stages 1-3: temperature difference, coefficient products, first-order
// temperature, offset and sensitivity.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_first_order (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic                       in_valid,
   input  wire logic [bpc_pkg::RAW_W-1:0]  raw_pressure,
   input  wire logic [bpc_pkg::RAW_W-1:0]  raw_temperature,
   input  wire bpc_pkg::coef_type          coef,
   output logic                            out_valid,
   output bpc_pkg::fo_type                 out_data
);

   logic                       s1_v_ff;
   logic [bpc_pkg::RAW_W-1:0]  s1_d1_ff;
   logic signed [24:0]         s1_dt_ff, s1_dt_in;

   logic                       s2_v_ff;
   logic [bpc_pkg::RAW_W-1:0]  s2_d1_ff;
   logic signed [41:0]         s2_mt_ff, s2_mt_in;
   logic signed [41:0]         s2_mo_ff, s2_mo_in;
   logic signed [41:0]         s2_ms_ff, s2_ms_in;
   logic signed [49:0]         s2_mdd_ff, s2_mdd_in;

   logic                       s3_v_ff;
   bpc_pkg::fo_type            s3_ff, s3_in;

   logic signed [16:0]         c3_s, c4_s, c6_s;
   logic [18:0]                lo;

   assign s1_dt_in = $signed({1'b0, raw_temperature}) - $signed({1'b0, coef.c5, 8'd0});

   assign c3_s = $signed({1'b0, coef.c3});
   assign c4_s = $signed({1'b0, coef.c4});
   assign c6_s = $signed({1'b0, coef.c6});

   assign s2_mt_in  = s1_dt_ff * c6_s;
   assign s2_mo_in  = s1_dt_ff * c4_s;
   assign s2_ms_in  = s1_dt_ff * c3_s;
   assign s2_mdd_in = s1_dt_ff * s1_dt_ff;

   // floor shifts are plain slices of the signed products
   assign lo = s2_mt_ff[41:23];

   always_comb begin
      s3_in.d1    = s2_d1_ff;
      s3_in.lo    = lo;
      s3_in.temp1 = {lo[18], lo} + bpc_pkg::TEMP_REF;
      s3_in.vl    = {lo[18], lo} + bpc_pkg::TEMP_VLOW_OFS;
      s3_in.off1  = {4'd0, coef.c2, 16'd0} + {s2_mo_ff[41], s2_mo_ff[41:7]};
      s3_in.sens1 = {4'd0, coef.c1, 15'd0} + {s2_ms_ff[41], s2_ms_ff[41:8]};
      s3_in.t2    = s2_mdd_ff[48:31];
      s3_in.low   = lo[18];
      s3_in.vlow  = s3_in.vl[19];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= in_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_d1_ff  <= raw_pressure;
         s1_dt_ff  <= s1_dt_in;
         s2_d1_ff  <= s1_d1_ff;
         s2_mt_ff  <= s2_mt_in;
         s2_mo_ff  <= s2_mo_in;
         s2_ms_ff  <= s2_ms_in;
         s2_mdd_ff <= s2_mdd_in;
         s3_ff     <= s3_in;
      end
   end

   assign out_valid = s3_v_ff;
   assign out_data  = s3_ff;

endmodule

`default_nettype wire

/* hw/rtl/bpc_second_order.sv */
// ----------------------------------------------------------------------------
// bpc_second_order
// Stages 4-6: low-temperature correction terms and their subtraction.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_second_order (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire bpc_pkg::fo_type  in_data,
   output logic                  out_valid,
   output bpc_pkg::so_type       out_data
);

   logic             s4_v_ff;
   bpc_pkg::fo_type  s4_fo_ff;
   logic [34:0]      s4_lo2_ff, s4_lo2_in;
   logic [34:0]      s4_vl2_ff, s4_vl2_in;

   logic             s5_v_ff;
   bpc_pkg::fo_type  s5_fo_ff;
   logic [37:0]      s5_off2_ff, s5_off2_in;
   logic [37:0]      s5_sens2_ff, s5_sens2_in;

   logic             s6_v_ff;
   bpc_pkg::so_type  s6_ff, s6_in;

   logic [34:0]      lo_x, vl_x;
   logic [37:0]      m5, m7, m11;

   assign lo_x = {{16{in_data.lo[18]}}, in_data.lo};
   assign vl_x = {{15{in_data.vl[19]}}, in_data.vl};

   // low bits of the squares; both fit in 35 bits when they are used
   assign s4_lo2_in = lo_x * lo_x;
   assign s4_vl2_in = vl_x * vl_x;

   assign m5  = {3'd0, s4_lo2_ff} + {1'b0, s4_lo2_ff, 2'd0};
   assign m7  = {s4_vl2_ff, 3'd0} - {3'd0, s4_vl2_ff};
   assign m11 = {s4_vl2_ff, 3'd0} + {2'd0, s4_vl2_ff, 1'b0} + {3'd0, s4_vl2_ff};

   assign s5_off2_in  = {1'b0, m5[37:1]} + (s4_fo_ff.vlow ? m7 : 38'd0);
   assign s5_sens2_in = {2'd0, m5[37:2]} + (s4_fo_ff.vlow ? {1'b0, m11[37:1]} : 38'd0);

   always_comb begin
      s6_in.d1   = s5_fo_ff.d1;
      s6_in.temp = {s5_fo_ff.temp1[19], s5_fo_ff.temp1};
      s6_in.off  = {{4{s5_fo_ff.off1[35]}}, s5_fo_ff.off1};
      s6_in.sens = {{5{s5_fo_ff.sens1[34]}}, s5_fo_ff.sens1};
      if (s5_fo_ff.low) begin
         s6_in.temp = s6_in.temp - {3'd0, s5_fo_ff.t2};
         s6_in.off  = s6_in.off - {2'd0, s5_off2_ff};
         s6_in.sens = s6_in.sens - {2'd0, s5_sens2_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
      end else if (en) begin
         s4_v_ff <= in_valid;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_fo_ff    <= in_data;
         s4_lo2_ff   <= s4_lo2_in;
         s4_vl2_ff   <= s4_vl2_in;
         s5_fo_ff    <= s4_fo_ff;
         s5_off2_ff  <= s5_off2_in;
         s5_sens2_ff <= s5_sens2_in;
         s6_ff       <= s6_in;
      end
   end

   assign out_valid = s6_v_ff;
   assign out_data  = s6_ff;

endmodule

`default_nettype wire

/* hw/rtl/bpc_pressure.sv */
// ----------------------------------------------------------------------------
// bpc_pressure
// Stages 7-8: split sensitivity product and its recombination; result
// register with a skid entry that holds the pipeline while full.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_pressure (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire bpc_pkg::so_type  in_data,
   output logic                  en,
   bpc_rsp_if.source             rsp_bus
);

   logic                 s7_v_ff;
   logic [43:0]          s7_pp_lo_ff, s7_pp_lo_in;
   logic signed [44:0]   s7_pp_hi_ff, s7_pp_hi_in;
   logic [39:0]          s7_off_ff;
   logic [20:0]          s7_temp_ff;

   logic                 s8_v_ff;
   logic [43:0]          s8_q_ff;
   logic [39:0]          s8_off_ff;
   logic [20:0]          s8_temp_ff;

   logic                 rsp_v_ff, rsp_v_in;
   logic                 skid_v_ff, skid_v_in;
   logic [31:0]          rsp_temp_ff, rsp_pres_ff;
   logic [31:0]          skid_temp_ff, skid_pres_ff;
   logic                 load_rsp_new, load_rsp_skid, load_skid;

   logic [64:0]          prod;
   logic [44:0]          diff;
   logic [31:0]          new_temp, new_pres;
   logic                 arrive, take;

   assign en = !skid_v_ff;

   assign s7_pp_lo_in = in_data.d1 * in_data.sens[19:0];
   assign s7_pp_hi_in = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[39:20]);

   assign prod = {s7_pp_hi_ff, 20'd0} + {21'd0, s7_pp_lo_ff};

   assign diff     = {s8_q_ff[43], s8_q_ff} - {{5{s8_off_ff[39]}}, s8_off_ff};
   assign new_pres = {{2{diff[44]}}, diff[44:15]};
   assign new_temp = {{11{s8_temp_ff[20]}}, s8_temp_ff};

   assign arrive = s8_v_ff && en;
   assign take   = rsp_v_ff && rsp_bus.ready;

   always_comb begin
      rsp_v_in      = rsp_v_ff;
      skid_v_in     = skid_v_ff;
      load_rsp_new  = 1'b0;
      load_rsp_skid = 1'b0;
      load_skid     = 1'b0;
      priority if (skid_v_ff) begin
         if (take) begin
            load_rsp_skid = 1'b1;
            skid_v_in     = 1'b0;
         end
      end else if (arrive) begin
         if (!rsp_v_ff || take) begin
            load_rsp_new = 1'b1;
            rsp_v_in     = 1'b1;
         end else begin
            load_skid = 1'b1;
            skid_v_in = 1'b1;
         end
      end else if (take) begin
         rsp_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_v_ff   <= 1'b0;
         s8_v_ff   <= 1'b0;
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (en) begin
            s7_v_ff <= in_valid;
            s8_v_ff <= s7_v_ff;
         end
         rsp_v_ff  <= rsp_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_pp_lo_ff <= s7_pp_lo_in;
         s7_pp_hi_ff <= s7_pp_hi_in;
         s7_off_ff   <= in_data.off;
         s7_temp_ff  <= in_data.temp;
         s8_q_ff     <= prod[64:21];
         s8_off_ff   <= s7_off_ff;
         s8_temp_ff  <= s7_temp_ff;
      end
      if (load_rsp_new) begin
         rsp_temp_ff <= new_temp;
         rsp_pres_ff <= new_pres;
      end else if (load_rsp_skid) begin
         rsp_temp_ff <= skid_temp_ff;
         rsp_pres_ff <= skid_pres_ff;
      end
      if (load_skid) begin
         skid_temp_ff <= new_temp;
         skid_pres_ff <= new_pres;
      end
   end

   assign rsp_bus.valid             = rsp_v_ff;
   assign rsp_bus.temperature_centi = $signed(rsp_temp_ff);
   assign rsp_bus.pressure_centi    = $signed(rsp_pres_ff);

endmodule

`default_nettype wire
